[design/lcfs_pkg.sv]
// Shared constants, types and the base color table of the fragment shader.
package lcfs_pkg;

    localparam int COLOR_BITS_DEF   = 8;
    localparam int UV_FRAC_BITS_DEF = 8;

    localparam logic [15:0] LIGHT_X_RST = 16'd256;
    localparam logic [15:0] LIGHT_Y_RST = 16'd512;
    localparam logic [15:0] LIGHT_Z_RST = 16'd384;

    // Configuration register indexes
    localparam logic [1:0] REG_LIGHT_X = 2'd0;
    localparam logic [1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [1:0] REG_LIGHT_Z = 2'd2;

    // Q16 shading constants
    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [16:0] AMBIENT_Q16    = 17'd11796;
    localparam logic [15:0] DIFFUSE_Q16    = 16'd53740;
    localparam logic [16:0] CHECK_DARK_Q16 = 17'd51118;
    localparam logic [32:0] HALF_Q16       = 33'd32768;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;

    // Per-item sideband carried down the pipe
    typedef struct packed {
        logic       chk_hi;
        logic [1:0] kind;
    } t_side;

    // Base color in Q16 for block kind and channel (0 red, 1 green, 2 blue)
    function automatic logic [15:0] base_color(input logic [1:0] kind, input logic [1:0] ch);
        logic [15:0] v;
        v = 16'd0;
        unique case (kind)
            2'd0: v = 16'd47186;
            2'd1: begin
                unique case (ch)
                    2'd0:    v = 16'd19661;
                    2'd1:    v = 16'd44564;
                    default: v = 16'd20972;
                endcase
            end
            2'd2: begin
                unique case (ch)
                    2'd0:    v = 16'd40632;
                    2'd1:    v = 16'd26214;
                    default: v = 16'd13107;
                endcase
            end
            default: begin
                unique case (ch)
                    2'd0:    v = 16'd18350;
                    2'd1:    v = 16'd31457;
                    default: v = 16'd49152;
                endcase
            end
        endcase
        return v;
    endfunction

endpackage

[design/lambert_checker_fragment_shader_unit.sv]
// Top level of the Lambert fragment shader with checker texture.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_ready      | normal x/y/z, tex u/v, block kind
//   out     | output    | o_out_valid / i_out_ready    | red, green, blue
//   cfg     | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is taken; 3 front stages, 32 square
// root stages (one result bit each), 17 divider stages (setup plus one quotient
// bit each) and 4 color stages ending in the output register.
// Synchronous active-low reset clears valid bits and restores the light direction.
// The whole pipe holds while the output register is full and not taken.
module lambert_checker_fragment_shader_unit #(
    parameter int COLOR_BITS   = lcfs_pkg::COLOR_BITS_DEF,
    parameter int UV_FRAC_BITS = lcfs_pkg::UV_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [15:0]     i_normal_x,
    input  logic signed [15:0]     i_normal_y,
    input  logic signed [15:0]     i_normal_z,
    input  logic signed [15:0]     i_tex_u,
    input  logic signed [15:0]     i_tex_v,
    input  logic [15:0]            i_block_kind,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COLOR_BITS-1:0]  o_red,
    output logic [COLOR_BITS-1:0]  o_green,
    output logic [COLOR_BITS-1:0]  o_blue
);

    logic [15:0]        r_lx, r_ly, r_lz;
    logic               w_en;
    logic               w_fv, w_sv, w_dv;
    logic [63:0]        w_p;
    logic signed [32:0] w_fd, w_sd;
    logic [31:0]        w_s;
    logic [16:0]        w_diff;
    lcfs_pkg::t_side    w_fside, w_sside, w_dside;

    // light direction registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lx <= lcfs_pkg::LIGHT_X_RST;
            r_ly <= lcfs_pkg::LIGHT_Y_RST;
            r_lz <= lcfs_pkg::LIGHT_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lcfs_pkg::REG_LIGHT_X: r_lx <= i_cfg_data;
                lcfs_pkg::REG_LIGHT_Y: r_ly <= i_cfg_data;
                lcfs_pkg::REG_LIGHT_Z: r_lz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advances unless the output item is held
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    lcfs_front #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_nx    (i_normal_x),
        .i_ny    (i_normal_y),
        .i_nz    (i_normal_z),
        .i_u     (i_tex_u),
        .i_v     (i_tex_v),
        .i_kind  (i_block_kind[1:0]),
        .i_lx    ($signed(r_lx)),
        .i_ly    ($signed(r_ly)),
        .i_lz    ($signed(r_lz)),
        .o_valid (w_fv),
        .o_p     (w_p),
        .o_d     (w_fd),
        .o_side  (w_fside)
    );

    lcfs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_p     (w_p),
        .i_d     (w_fd),
        .i_side  (w_fside),
        .o_valid (w_sv),
        .o_s     (w_s),
        .o_d     (w_sd),
        .o_side  (w_sside)
    );

    lcfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_s     (w_s),
        .i_d     (w_sd),
        .i_side  (w_sside),
        .o_valid (w_dv),
        .o_diff  (w_diff),
        .o_side  (w_dside)
    );

    lcfs_color #(.COLOR_BITS(COLOR_BITS)) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_diff  (w_diff),
        .i_side  (w_dside),
        .o_valid (o_out_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

[design/lcfs_front.sv]
// Front stages: products, sums of squares and dot, then |n|^2 * |l|^2.
module lcfs_front #(
    parameter int UV_FRAC_BITS = lcfs_pkg::UV_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [15:0]    i_nx,
    input  logic signed [15:0]    i_ny,
    input  logic signed [15:0]    i_nz,
    input  logic signed [15:0]    i_u,
    input  logic signed [15:0]    i_v,
    input  logic [1:0]            i_kind,
    input  logic signed [15:0]    i_lx,
    input  logic signed [15:0]    i_ly,
    input  logic signed [15:0]    i_lz,
    output logic                  o_valid,
    output logic [63:0]           o_p,
    output logic signed [32:0]    o_d,
    output lcfs_pkg::t_side       o_side
);

    logic                r_v1, r_v2, r_v3;
    logic signed [31:0]  r_nn [3];
    logic signed [31:0]  r_ll [3];
    logic signed [31:0]  r_nl [3];
    lcfs_pkg::t_side     r_s1, r_s2, r_s3;
    logic [31:0]         r_n2, r_l2;
    logic signed [32:0]  r_d2, r_d3;
    logic [63:0]         r_p;
    logic [15:0]         w_mu, w_mv;
    lcfs_pkg::t_side     w_side;

    // checker parity: truncation toward zero means magnitude
    always_comb begin
        w_mu = i_u[15] ? 16'(-i_u) : i_u;
        w_mv = i_v[15] ? 16'(-i_v) : i_v;
        w_side.chk_hi = w_mu[UV_FRAC_BITS-1] ^ w_mv[UV_FRAC_BITS-1];
        w_side.kind   = i_kind;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nn[0] <= i_nx * i_nx;
            r_nn[1] <= i_ny * i_ny;
            r_nn[2] <= i_nz * i_nz;
            r_ll[0] <= i_lx * i_lx;
            r_ll[1] <= i_ly * i_ly;
            r_ll[2] <= i_lz * i_lz;
            r_nl[0] <= i_nx * i_lx;
            r_nl[1] <= i_ny * i_ly;
            r_nl[2] <= i_nz * i_lz;
            r_s1    <= w_side;

            r_n2 <= $unsigned(r_nn[0]) + $unsigned(r_nn[1]) + $unsigned(r_nn[2]);
            r_l2 <= $unsigned(r_ll[0]) + $unsigned(r_ll[1]) + $unsigned(r_ll[2]);
            r_d2 <= 33'(r_nl[0]) + 33'(r_nl[1]) + 33'(r_nl[2]);
            r_s2 <= r_s1;

            r_p  <= 64'(r_n2) * 64'(r_l2);
            r_d3 <= r_d2;
            r_s3 <= r_s2;
        end
    end

    assign o_valid = r_v3;
    assign o_p     = r_p;
    assign o_d     = r_d3;
    assign o_side  = r_s3;

endmodule

[design/lcfs_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module lcfs_sqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [63:0]           i_p,
    input  logic signed [32:0]    i_d,
    input  lcfs_pkg::t_side       i_side,
    output logic                  o_valid,
    output logic [31:0]           o_s,
    output logic signed [32:0]    o_d,
    output lcfs_pkg::t_side       o_side
);

    localparam int N = lcfs_pkg::SQRT_STEPS;

    logic               w_v [N+1];
    logic [63:0]        w_x [N+1];
    logic [63:0]        w_r [N+1];
    logic signed [32:0] w_d [N+1];
    lcfs_pkg::t_side    w_s [N+1];

    assign w_v[0] = i_valid;
    assign w_x[0] = i_p;
    assign w_r[0] = 64'd0;
    assign w_d[0] = i_d;
    assign w_s[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic               r_v;
        logic [63:0]        r_x, r_r;
        logic signed [32:0] r_d;
        lcfs_pkg::t_side    r_s;
        logic [64:0]        w_t;
        logic [63:0]        n_x, n_r;

        // trial subtract of r + bit
        always_comb begin
            w_t = 65'(w_r[k]) + 65'(BIT);
            if (65'(w_x[k]) >= w_t) begin
                n_x = w_x[k] - w_t[63:0];
                n_r = (w_r[k] >> 1) + BIT;
            end else begin
                n_x = w_x[k];
                n_r = w_r[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_r <= n_r;
                r_d <= w_d[k];
                r_s <= w_s[k];
            end
        end

        assign w_v[k+1] = r_v;
        assign w_x[k+1] = r_x;
        assign w_r[k+1] = r_r;
        assign w_d[k+1] = r_d;
        assign w_s[k+1] = r_s;
    end

    assign o_valid = w_v[N];
    assign o_s     = w_r[N][31:0];
    assign o_d     = w_d[N];
    assign o_side  = w_s[N];

endmodule

[design/lcfs_div.sv]
// Diffuse term: dot / sqrt in Q16, restoring division one bit per stage.
module lcfs_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_s,
    input  logic signed [32:0]    i_d,
    input  lcfs_pkg::t_side       i_side,
    output logic                  o_valid,
    output logic [16:0]           o_diff,
    output lcfs_pkg::t_side       o_side
);

    localparam int N = lcfs_pkg::DIV_STEPS;

    // setup stage: classify and load remainder
    logic            r_v0, r_pos0, r_full0;
    logic [32:0]     r_rem0;
    logic [31:0]     r_s0;
    lcfs_pkg::t_side r_side0;
    logic            w_pos;

    assign w_pos = (i_d > 33'sd0) && (i_s != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos0  <= w_pos;
            r_full0 <= w_pos && ($unsigned(i_d) >= 33'(i_s));
            r_rem0  <= $unsigned(i_d);
            r_s0    <= i_s;
            r_side0 <= i_side;
        end
    end

    logic            w_v    [N+1];
    logic            w_pos2 [N+1];
    logic            w_full [N+1];
    logic [32:0]     w_rem  [N+1];
    logic [31:0]     w_s    [N+1];
    logic [15:0]     w_q    [N+1];
    lcfs_pkg::t_side w_sd   [N+1];

    assign w_v[0]    = r_v0;
    assign w_pos2[0] = r_pos0;
    assign w_full[0] = r_full0;
    assign w_rem[0]  = r_rem0;
    assign w_s[0]    = r_s0;
    assign w_q[0]    = 16'd0;
    assign w_sd[0]   = r_side0;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic            r_v, r_pos, r_full;
        logic [32:0]     r_rem;
        logic [31:0]     r_s;
        logic [15:0]     r_q;
        lcfs_pkg::t_side r_sd;
        logic [33:0]     w_sh;
        logic [32:0]     n_rem;
        logic            n_bit;

        // shift in a zero and trial subtract the divisor
        always_comb begin
            w_sh = {w_rem[k], 1'b0};
            if (w_sh >= 34'(w_s[k])) begin
                n_rem = 33'(w_sh - 34'(w_s[k]));
                n_bit = 1'b1;
            end else begin
                n_rem = w_sh[32:0];
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pos  <= w_pos2[k];
                r_full <= w_full[k];
                r_rem  <= n_rem;
                r_s    <= w_s[k];
                r_q    <= {w_q[k][14:0], n_bit};
                r_sd   <= w_sd[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_pos2[k+1] = r_pos;
        assign w_full[k+1] = r_full;
        assign w_rem[k+1]  = r_rem;
        assign w_s[k+1]    = r_s;
        assign w_q[k+1]    = r_q;
        assign w_sd[k+1]   = r_sd;
    end

    // clamp at one; non-facing or degenerate vectors give zero
    always_comb begin
        if (w_full[N]) begin
            o_diff = lcfs_pkg::ONE_Q16;
        end else if (w_pos2[N]) begin
            o_diff = 17'(w_q[N]);
        end else begin
            o_diff = 17'd0;
        end
    end

    assign o_valid = w_v[N];
    assign o_side  = w_sd[N];

endmodule

[design/lcfs_color.sv]
// Color stages: light factor, base color, checker, unorm scale and output register.
module lcfs_color #(
    parameter int COLOR_BITS = lcfs_pkg::COLOR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [16:0]            i_diff,
    input  lcfs_pkg::t_side        i_side,
    output logic                   o_valid,
    output logic [COLOR_BITS-1:0]  o_red,
    output logic [COLOR_BITS-1:0]  o_green,
    output logic [COLOR_BITS-1:0]  o_blue
);

    localparam logic [32:0] MAXV = 33'((34'd1 << COLOR_BITS) - 34'd1);

    logic            r_va, r_vb, r_vc, r_vd;
    logic [16:0]     r_lit;
    lcfs_pkg::t_side r_sa, r_sb;
    logic [16:0]     r_t [3];
    logic [16:0]     r_c [3];
    logic [COLOR_BITS-1:0] r_q [3];
    logic [32:0]     w_dm;
    logic [32:0]     w_tp [3];
    logic [32:0]     w_cp [3];
    logic [32:0]     w_qp [3];
    logic [COLOR_BITS-1:0] n_q [3];
    logic [16:0]     w_chk;

    assign w_dm  = 33'(lcfs_pkg::DIFFUSE_Q16) * 33'(i_diff);
    assign w_chk = r_sb.chk_hi ? lcfs_pkg::ONE_Q16 : lcfs_pkg::CHECK_DARK_Q16;

    // per-channel products with rounding
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_tp[ch] = 33'(r_lit) * 33'(lcfs_pkg::base_color(r_sa.kind, 2'(ch)))
                       + lcfs_pkg::HALF_Q16;
            w_cp[ch] = 33'(r_t[ch]) * 33'(w_chk) + lcfs_pkg::HALF_Q16;
            w_qp[ch] = 33'(r_c[ch]) * MAXV + lcfs_pkg::HALF_Q16;
            if ((w_qp[ch] >> 16) > MAXV) begin
                n_q[ch] = MAXV[COLOR_BITS-1:0];
            end else begin
                n_q[ch] = w_qp[ch][16 +: COLOR_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lit <= lcfs_pkg::AMBIENT_Q16 + w_dm[32:16];
            r_sa  <= i_side;
            r_sb  <= r_sa;
            for (int ch = 0; ch < 3; ch++) begin
                r_t[ch] <= w_tp[ch][32:16];
                r_c[ch] <= w_cp[ch][32:16];
                r_q[ch] <= n_q[ch];
            end
        end
    end

    assign o_valid = r_vd;
    assign o_red   = r_q[0];
    assign o_green = r_q[1];
    assign o_blue  = r_q[2];

endmodule
